[rtl/debounced_toggle_with_adc_blink_assert.svh]
// assertion macros for the debounced toggle block
`ifndef DEBOUNCED_TOGGLE_WITH_ADC_BLINK_ASSERT_SVH
`define DEBOUNCED_TOGGLE_WITH_ADC_BLINK_ASSERT_SVH

`ifndef SYNTH

`define DTAB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

`define DTAB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`else

`define DTAB_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define DTAB_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/dtab_pkg.sv]
// shared types and constants of the debounced toggle block
package dtab_pkg;

	localparam int NUM_KEYS         = 4;
	localparam int DEBOUNCE_SAMPLES = 3;

	localparam int KEY_W  = 4;
	localparam int OUT_W  = 4;
	localparam int PAD_W  = (NUM_KEYS > OUT_W) ? NUM_KEYS : OUT_W;
	localparam int ADC_W  = 10;
	localparam int CD_W   = ADC_W + 2;
	localparam int NUM_CH = 2;

	localparam logic [ADC_W-1:0] THR_RESET = ADC_W'(1016);

	typedef enum logic [1:0] {
		KIND_POLL = 2'd0,
		KIND_TICK = 2'd1,
		KIND_ADC  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		LVL_PRESSED  = 2'd0,
		LVL_RELEASED = 2'd1,
		LVL_UNKNOWN  = 2'd2
	} level_t;

	typedef struct packed {
		kind_t             kind;
		logic [KEY_W-1:0]  key_levels;
		logic              adc_channel;
		logic [ADC_W-1:0]  adc_value;
	} item_t;

endpackage

[rtl/dtab_keys.sv]
// per-key shift register debounce and press detection
`include "debounced_toggle_with_adc_blink_assert.svh"

module dtab_keys (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  dtab_pkg::item_t               item,
	output logic [dtab_pkg::NUM_KEYS-1:0] toggle,
	output logic [dtab_pkg::NUM_KEYS-1:0] pressed
);

	logic [dtab_pkg::DEBOUNCE_SAMPLES-1:0] hist_q  [dtab_pkg::NUM_KEYS];
	logic [dtab_pkg::DEBOUNCE_SAMPLES-1:0] hist_nx [dtab_pkg::NUM_KEYS];
	dtab_pkg::level_t                      stable_q  [dtab_pkg::NUM_KEYS];
	dtab_pkg::level_t                      stable_nx [dtab_pkg::NUM_KEYS];
	logic [dtab_pkg::NUM_KEYS-1:0]         raw;
	logic                                  poll;

	assign raw  = dtab_pkg::NUM_KEYS'(item.key_levels);
	assign poll = go && (item.kind == dtab_pkg::KIND_POLL);

	always_comb begin
		for (int i = 0; i < dtab_pkg::NUM_KEYS; i++) begin
			hist_nx[i]   = hist_q[i];
			stable_nx[i] = stable_q[i];
			toggle[i]    = 1'b0;
			if (poll) begin
				hist_nx[i] = {hist_q[i][dtab_pkg::DEBOUNCE_SAMPLES-2:0], raw[i]};
				if (hist_nx[i] == '0) begin
					stable_nx[i] = dtab_pkg::LVL_PRESSED;
					toggle[i]    = (stable_q[i] != dtab_pkg::LVL_PRESSED);
				end else if (hist_nx[i] == '1) begin
					stable_nx[i] = dtab_pkg::LVL_RELEASED;
				end
			end
			pressed[i] = (stable_nx[i] == dtab_pkg::LVL_PRESSED);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dtab_pkg::NUM_KEYS; i++) begin
				hist_q[i]   <= '0;
				stable_q[i] <= dtab_pkg::LVL_UNKNOWN;
			end
		end else begin
			for (int i = 0; i < dtab_pkg::NUM_KEYS; i++) begin
				hist_q[i]   <= hist_nx[i];
				stable_q[i] <= stable_nx[i];
			end
		end
	end

	// a toggle only comes with a fresh stable press
	`DTAB_ASSERT_IMP(a_toggle_pressed, clk, arst_n, go, (toggle & ~pressed) == '0)
	`DTAB_ASSERT_IMP(a_toggle_poll, clk, arst_n, !poll, toggle == '0)

endmodule

[rtl/dtab_blink.sv]
// adc readings, blink threshold and alternating blink countdowns
`include "debounced_toggle_with_adc_blink_assert.svh"

module dtab_blink (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  dtab_pkg::item_t             item,
	input  logic                        cfg_we,
	input  logic [dtab_pkg::ADC_W-1:0]  cfg_data,
	output logic [dtab_pkg::NUM_CH-1:0] toggle
);

	logic [dtab_pkg::ADC_W-1:0] reading_q   [dtab_pkg::NUM_CH];
	logic [dtab_pkg::CD_W-1:0]  countdown_q [dtab_pkg::NUM_CH];
	logic [dtab_pkg::ADC_W-1:0] thr_q;
	logic                       tick_ch_q;
	logic                       tick;
	logic                       active;
	logic                       cd_zero;

	assign tick    = go && (item.kind == dtab_pkg::KIND_TICK);
	assign active  = reading_q[tick_ch_q] < thr_q;
	assign cd_zero = countdown_q[tick_ch_q] == '0;

	always_comb begin
		toggle = '0;
		toggle[tick_ch_q] = tick && active && cd_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < dtab_pkg::NUM_CH; c++) begin
				reading_q[c]   <= '0;
				countdown_q[c] <= '0;
			end
			thr_q     <= dtab_pkg::THR_RESET;
			tick_ch_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (go && (item.kind == dtab_pkg::KIND_ADC)) begin
				reading_q[item.adc_channel] <= item.adc_value;
			end
			if (tick) begin
				tick_ch_q <= ~tick_ch_q;
				if (active) begin
					if (cd_zero) begin
						countdown_q[tick_ch_q] <= {reading_q[tick_ch_q], 2'b00};
					end else begin
						countdown_q[tick_ch_q] <= countdown_q[tick_ch_q] - 1'b1;
					end
				end
			end
		end
	end

	`DTAB_ASSERT_NXT(a_tick_alternates, clk, arst_n, tick, tick_ch_q != $past(tick_ch_q))
	`DTAB_ASSERT_NXT(a_pointer_holds, clk, arst_n, !tick, $stable(tick_ch_q))

endmodule

[rtl/debounced_toggle_with_adc_blink.sv]
// top level of the debounced toggle block with adc driven blink
// a result passes the input register, then the result register, and is held while the output stalls
// throughput: one item per cycle while out_ready is high, input register and result register
// the result register frees the input side while a result waits
// reset: key histories cleared and key levels unknown, blink and output state cleared, threshold set to 1016
module debounced_toggle_with_adc_blink (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [dtab_pkg::KEY_W-1:0] key_levels,
	input  logic                       adc_channel,
	input  logic [dtab_pkg::ADC_W-1:0] adc_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dtab_pkg::OUT_W-1:0] out_levels,
	output logic [dtab_pkg::OUT_W-1:0] key_pressed,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [dtab_pkg::ADC_W-1:0] cfg_data
);

	dtab_pkg::item_t               item_in;
	dtab_pkg::item_t               item_s1;
	logic                          valid_s1;
	logic                          valid_s2;
	logic [dtab_pkg::OUT_W-1:0]    levels_s2;
	logic [dtab_pkg::OUT_W-1:0]    pressed_s2;
	logic [dtab_pkg::NUM_KEYS-1:0] out_state_q;
	logic [dtab_pkg::NUM_KEYS-1:0] out_state_nx;
	logic [dtab_pkg::NUM_KEYS-1:0] key_tog;
	logic [dtab_pkg::NUM_KEYS-1:0] key_prs;
	logic [dtab_pkg::NUM_CH-1:0]   blink_tog;
	logic [dtab_pkg::PAD_W-1:0]    state_pad;
	logic [dtab_pkg::PAD_W-1:0]    pressed_pad;
	logic                          adv;

	always_comb begin
		item_in.kind        = dtab_pkg::kind_t'(kind);
		item_in.key_levels  = key_levels;
		item_in.adc_channel = adc_channel;
		item_in.adc_value   = adc_value;
	end

	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	dtab_keys u_keys (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (adv),
		.item    (item_s1),
		.toggle  (key_tog),
		.pressed (key_prs)
	);

	dtab_blink u_blink (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (adv),
		.item     (item_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.toggle   (blink_tog)
	);

	// blink channels map onto the low outputs
	assign out_state_nx = out_state_q ^ key_tog ^ dtab_pkg::NUM_KEYS'(blink_tog);
	assign state_pad    = dtab_pkg::PAD_W'(out_state_nx);
	assign pressed_pad  = dtab_pkg::PAD_W'(key_prs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_state_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2    <= 1'b1;
				out_state_q <= out_state_nx;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
		if (adv) begin
			levels_s2  <= state_pad[dtab_pkg::OUT_W-1:0];
			pressed_s2 <= pressed_pad[dtab_pkg::OUT_W-1:0];
		end
	end

	assign out_valid   = valid_s2;
	assign out_levels  = levels_s2;
	assign key_pressed = pressed_s2;

	`DTAB_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && valid_s2 && !out_ready)
	`DTAB_ASSERT_NXT(a_result_follows, clk, arst_n, adv, valid_s2)

endmodule
